[src/mqip_pkg.sv]
// Shared types and codes for the multi-queue store with indexed peek.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none

package mqip_pkg;

  // operation codes carried in tuser
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned QID_W    = 4;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IN_TDATA_W  = 40;  // push_value + peek_index, byte padded
  localparam int unsigned IN_TUSER_W  = CMD_W + QID_W;
  localparam int unsigned OUT_TDATA_W = WORD_W;
  localparam int unsigned OUT_TUSER_W = STATUS_W;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // input word accepted this cycle
    logic look;      // fetch front/count of the addressed queue
    logic exec;      // ring arithmetic, store access, pointer update
    logic load_out;  // move result into output register
  } mqip_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;  // output register holds a word not yet taken
  } mqip_sts_t;

endpackage

`default_nettype wire

[src/multi_queue_indexed_peek.sv]
// Multi-queue word store with indexed peek: NUM_QUEUES ring buffers of DEPTH
// 32-bit words in one shared single-port store. Each input word is a push,
// pop or query (1-based position from the front, zero read as one, positions
// past the back return the back word) on one queue, and gives exactly one
// result word carrying the read data and a status (ok, full, empty). After
// the accepting edge an operation passes through queue pointer lookup, ring
// arithmetic with the store access, and response in turn; the next word is
// accepted only after the result word has been loaded into the output
// register, so the sequencer walks one operation at a time through the
// single store port.
// The output register lets the next operation be accepted while a result
// waits. Store contents need no clearing after reset.
// Depends on mqip_pkg, mqip_ctrl and mqip_dp.
`default_nettype none

module multi_queue_indexed_peek #(
  parameter int unsigned NUM_QUEUES = 16,
  parameter int unsigned DEPTH      = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [mqip_pkg::IN_TDATA_W-1:0]  in_tdata,   // push_value, peek_index
  input  wire logic [mqip_pkg::IN_TUSER_W-1:0]  in_tuser,   // cmd, queue_id
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [mqip_pkg::OUT_TDATA_W-1:0] out_tdata,  // read_data
  output logic      [mqip_pkg::OUT_TUSER_W-1:0] out_tuser   // status
);
  import mqip_pkg::*;

  mqip_cmd_t ctl_cmd;
  mqip_sts_t dp_sts;

  mqip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (dp_sts),
    .cmd       (ctl_cmd)
  );

  mqip_dp #(
    .NUM_QUEUES (NUM_QUEUES),
    .DEPTH      (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (ctl_cmd),
    .sts        (dp_sts)
  );

endmodule

`default_nettype wire

[src/mqip_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module mqip_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata <= mem_r[addr];
      end
    end
  end

endmodule

`default_nettype wire

[src/mqip_ctrl.sv]
// Operation sequencer: accept, lookup, execute, respond.
// Depends on mqip_pkg.
`default_nettype none

module mqip_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire mqip_pkg::mqip_sts_t sts,
  output mqip_pkg::mqip_cmd_t    cmd
);
  import mqip_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state_r;
  logic   in_tready_r;

  assign in_tready = in_tready_r;

  always_comb begin
    cmd.capture  = in_tvalid && in_tready_r;
    cmd.look     = (state_r == S_LOOK);
    cmd.exec     = (state_r == S_EXEC);
    cmd.load_out = (state_r == S_RESP) && !sts.out_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready_r) begin
            state_r     <= S_LOOK;
            in_tready_r <= 1'b0;
          end else begin
            in_tready_r <= 1'b1;
          end
        end
        S_LOOK: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (!sts.out_busy) begin
            state_r     <= S_IDLE;
            in_tready_r <= 1'b1;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          in_tready_r <= 1'b0;
        end
      endcase
    end
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready_r |-> state_r == S_IDLE)
    else $error("ready raised outside idle");

  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_LOOK)
    else $error("accepted word not followed by lookup");

  a_exec_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> $past(cmd.look))
    else $error("execute without lookup");

endmodule

`default_nettype wire

[src/mqip_dp.sv]
// Datapath: per-queue front/count registers, ring arithmetic, shared store
// and output register. Depends on mqip_pkg and mqip_ram.
`default_nettype none

module mqip_dp #(
  parameter int unsigned NUM_QUEUES = 16,
  parameter int unsigned DEPTH      = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [mqip_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic [mqip_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic      [mqip_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic      [mqip_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire mqip_pkg::mqip_cmd_t                 cmd,
  output mqip_pkg::mqip_sts_t                      sts
);
  import mqip_pkg::*;

  localparam int unsigned QW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned PTRW = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CNTW > IDX_W) ? CNTW : IDX_W;
  localparam int unsigned AW   = $clog2(NUM_QUEUES * DEPTH);

  // captured operation
  logic [CMD_W-1:0]  op_r;
  logic [QW-1:0]     qidx_r;
  logic              in_range_r;
  logic [WORD_W-1:0] value_r;
  logic [IDX_W-1:0]  idx_r;

  // per-queue state
  logic [PTRW-1:0] front_r [NUM_QUEUES];
  logic [CNTW-1:0] count_r [NUM_QUEUES];

  // selected queue after lookup
  logic [PTRW-1:0] front_sel_r;
  logic [CNTW-1:0] count_sel_r;

  logic [STATUS_W-1:0] status_r;
  logic                hit_r;

  logic [WORD_W-1:0]   out_data_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_tvalid_r;

  logic [8:0]      qid_ext;
  logic            is_empty;
  logic            is_full;
  logic [IDX_W-1:0] pos_raw;
  logic [CMPW-1:0] pos_cmp;
  logic [CMPW-1:0] cnt_cmp;
  logic [PTRW-1:0] pos;
  logic [PTRW-1:0] offset;
  logic [PTRW:0]   slot_sum;
  logic [PTRW-1:0] slot;
  logic [AW-1:0]   ram_addr;
  logic            ram_en;
  logic            ram_we;
  logic [WORD_W-1:0] ram_rdata;

  assign qid_ext = {5'd0, in_tuser[CMD_W +: QID_W]};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_tuser[CMD_W-1:0];
      qidx_r     <= qid_ext[QW-1:0];
      in_range_r <= (qid_ext < 9'(NUM_QUEUES));
      value_r    <= in_tdata[WORD_W-1:0];
      idx_r      <= in_tdata[WORD_W +: IDX_W];
    end
    if (cmd.look) begin
      front_sel_r <= front_r[qidx_r];
      count_sel_r <= count_r[qidx_r];
    end
  end

  assign is_empty = !in_range_r || (count_sel_r == '0);
  assign is_full  = !in_range_r || (count_sel_r >= CNTW'(DEPTH));

  // query position, index zero as one, clamped to the back word
  assign pos_raw = (idx_r == '0) ? '0 : idx_r - IDX_W'(1);
  assign pos_cmp = CMPW'(pos_raw);
  assign cnt_cmp = CMPW'(count_sel_r);
  assign pos     = (pos_cmp >= cnt_cmp) ? PTRW'(cnt_cmp - CMPW'(1)) : PTRW'(pos_cmp);

  always_comb begin
    unique case (op_r)
      OP_PUSH:  offset = PTRW'(count_sel_r);
      OP_POP:   offset = PTRW'(1);
      OP_QUERY: offset = pos;
      default:  offset = '0;
    endcase
  end

  assign slot_sum = {1'b0, front_sel_r} + {1'b0, offset};
  assign slot     = (slot_sum >= (PTRW+1)'(DEPTH)) ?
                    PTRW'(slot_sum - (PTRW+1)'(DEPTH)) : slot_sum[PTRW-1:0];
  assign ram_addr = AW'(qidx_r) * AW'(DEPTH) + AW'(slot);

  assign ram_we = cmd.exec && (op_r == OP_PUSH) && !is_full;
  assign ram_en = ram_we || (cmd.exec && (op_r == OP_QUERY) && !is_empty);

  mqip_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_QUEUES * DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (value_r),
    .rdata (ram_rdata)
  );

  // per-queue pointer update and result status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        front_r[i] <= '0;
        count_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      unique case (op_r)
        OP_PUSH: begin
          if (!is_full) begin
            count_r[qidx_r] <= count_sel_r + CNTW'(1);
          end
        end
        OP_POP: begin
          if (!is_empty) begin
            front_r[qidx_r] <= slot;
            count_r[qidx_r] <= count_sel_r - CNTW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      hit_r <= (op_r == OP_QUERY) && !is_empty;
      unique case (op_r)
        OP_PUSH:  status_r <= is_full  ? ST_FULL  : ST_OK;
        OP_POP:   status_r <= is_empty ? ST_EMPTY : ST_OK;
        OP_QUERY: status_r <= is_empty ? ST_EMPTY : ST_OK;
        default:  status_r <= ST_OK;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r   <= hit_r ? ram_rdata : '0;
      out_status_r <= status_r;
    end
  end

  assign out_tdata    = out_data_r;
  assign out_tuser    = out_status_r;
  assign out_tvalid   = out_tvalid_r;
  assign sts.out_busy = out_tvalid_r && !out_tready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_tvalid_r && !out_tready))
    else $error("output word overwritten before taken");

  a_store_write_push: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (op_r == OP_PUSH) && in_range_r && (count_sel_r < CNTW'(DEPTH)))
    else $error("store written without a legal push");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> count_sel_r <= CNTW'(DEPTH))
    else $error("queue count above depth");

endmodule

`default_nettype wire
